FILE: hdl/gsls_pkg.sv
// Package for the Gauss-Seidel solver core: widths, defaults and shared types.
// No dependencies.
`default_nettype none
package gsls_pkg;
  localparam int NUM_UNKNOWNS_DEF = 8;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int ROW_W            = 3;
  localparam int COL_W            = 4;
  localparam int DATA_W           = 32;
  localparam int LIMIT_W          = 16;
  localparam int TOL_W            = 31;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b1;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = 16'd100;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 31'd66;

  // Divider request/response control bundle.
  typedef struct packed {
    logic start;
  } div_ctl_t;
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

FILE: hdl/gsls_if.sv
// Valid/ready stream interfaces for the solver core.
// Depends on gsls_pkg.
`default_nettype none
interface gsls_in_if import gsls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [DATA_W-1:0] coeff;
  logic                     load_last;
  modport source (output valid, row, col, coeff, load_last, input ready);
  modport sink (input valid, row, col, coeff, load_last, output ready);
endinterface

interface gsls_out_if import gsls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         var_index;
  logic signed [DATA_W-1:0] value;
  logic                     out_last;
  modport source (output valid, var_index, value, out_last, input ready);
  modport sink (input valid, var_index, value, out_last, output ready);
endinterface

interface gsls_cfg_if import gsls_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/gsls_div.sv
// Restoring divider: signed 64-bit numerator by signed 32-bit divisor,
// quotient truncated toward zero and saturated to 32 bits. Depends on gsls_pkg.
`default_nettype none
module gsls_div import gsls_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire div_ctl_t                 ctl,
  input  wire logic signed [63:0]       num,
  input  wire logic signed [DATA_W-1:0] den,
  output div_sts_t                      sts,
  output logic signed [DATA_W-1:0]      quo
);
  logic [63:0] mn_r, mn_nxt, q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [31:0] md_r;
  logic        neg_r, zero_r, nump_r, busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [64:0] trial;
  logic [63:0] anum;

  assign anum = num[63] ? (64'd0 - num) : num;
  assign trial = {rem_r[63:0], mn_r[63]} - {33'd0, md_r};

  // One quotient bit per cycle.
  always_comb begin
    rem_nxt = {rem_r[63:0], mn_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    if (!trial[64]) begin
      rem_nxt = trial;
      q_nxt[0] = 1'b1;
    end
    mn_nxt = {mn_r[62:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
        mn_r   <= anum;
        md_r   <= den[31] ? (32'd0 - den) : den;
        rem_r  <= '0;
        q_r    <= '0;
        neg_r  <= num[63] ^ den[31];
        zero_r <= (den == '0);
        nump_r <= !num[63] && (num != '0);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        mn_r  <= mn_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Saturate the magnitude and apply the sign.
  always_comb begin
    if (zero_r) begin
      quo = nump_r ? 32'sh7fffffff : (neg_r ? 32'sh80000000 : '0);
    end else if (neg_r) begin
      quo = (q_r >= 64'h80000000) ? 32'sh80000000 : (32'sd0 - q_r[31:0]);
    end else begin
      quo = (q_r > 64'h7fffffff) ? 32'sh7fffffff : q_r[31:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
endmodule
`default_nettype wire

FILE: hdl/gauss_seidel_linear_solver_core.sv
// Gauss-Seidel iterative solver core: matrix memory, sweep sequencer, output.
// Depends on gsls_pkg, gsls_if and gsls_div.
`default_nettype none
// Coefficients load at one request per cycle into the matrix memory. The
// request flagged load_last starts the solve; input is held off until all
// unknowns are delivered. The solve first clears both solution copies. Each
// unknown update reads the constant term, then reads and multiplies each of
// the N coefficients and subtracts every product but the diagonal one, then
// runs a 64-step restoring divide and writes its result. A sweep updates
// every unknown in turn and then checks all N for convergence; a solve
// clears, runs its sweeps and delivers the N unknowns. An iteration limit
// of zero skips the sweeps. A zero diagonal saturates by numerator sign;
// all results saturate to 32 bits.
module gauss_seidel_linear_solver_core import gsls_pkg::*; #(
  parameter int NUM_UNKNOWNS = NUM_UNKNOWNS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  gsls_in_if.sink    in_ch,
  gsls_out_if.source out_ch,
  gsls_cfg_if.sink   cfg_ch
);
  localparam int COLS  = NUM_UNKNOWNS + 1;
  localparam int DEPTH = NUM_UNKNOWNS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NUM_UNKNOWNS);
  localparam int CW    = $clog2(COLS);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_RD, S_MUL, S_ACC, S_DIVGO, S_DIVW, S_CHK, S_EMIT
  } state_t;

  state_t state_r;
  logic signed [DATA_W-1:0] mat_mem [DEPTH];
  logic signed [DATA_W-1:0] cur_mem [NUM_UNKNOWNS];
  logic signed [DATA_W-1:0] prv_mem [NUM_UNKNOWNS];
  logic signed [DATA_W-1:0] rd_r, diag_r;
  logic [AW-1:0]      raddr;
  logic [KW-1:0]      k_r;
  logic [CW-1:0]      c_r;
  logic signed [63:0] acc_r, prod_r;
  logic               pdiag_r;
  logic [LIMIT_W-1:0] limit_r, sweep_r;
  logic [TOL_W-1:0]   tol_r;
  logic               conv_r;
  div_ctl_t           dctl;
  div_sts_t           dsts;
  logic signed [DATA_W-1:0] dquo;
  logic signed [DATA_W-1:0] xval;
  logic signed [63:0] sub_res, diff;
  logic [63:0]        mag;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ITER_LIMIT_RST;
      tol_r   <= TOLERANCE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ITER_LIMIT: limit_r <= cfg_ch.data[LIMIT_W-1:0];
        REG_TOLERANCE:  tol_r   <= cfg_ch.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_LOAD);
  assign raddr = AW'(k_r * COLS + c_r);

  // Matrix memory: write on load, registered read during the sweep.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && (32'(in_ch.row) < NUM_UNKNOWNS)
        && (32'(in_ch.col) <= NUM_UNKNOWNS))
      mat_mem[AW'(in_ch.row * COLS + in_ch.col)] <= in_ch.coeff;
    rd_r <= mat_mem[raddr];
  end

  assign xval = cur_mem[KW'(c_r)];

  // Saturating subtract of the product from the accumulator.
  always_comb begin
    sub_res = acc_r - prod_r;
    if (acc_r[63] != prod_r[63] && sub_res[63] != acc_r[63])
      sub_res = acc_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  end

  assign diff = 64'(cur_mem[k_r]) - 64'(prv_mem[k_r]);
  assign mag  = diff[63] ? (64'd0 - diff) : diff;

  gsls_div u_div (
    .clk, .rst_n, .ctl(dctl), .num(acc_r), .den(diag_r), .sts(dsts), .quo(dquo)
  );
  assign dctl.start = (state_r == S_DIVGO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      out_ch.valid <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: if (in_ch.valid && in_ch.load_last) begin
          state_r <= S_INIT;
          k_r <= '0;
        end
        S_INIT: begin
          // Clear both solution copies one entry a cycle.
          cur_mem[k_r] <= '0;
          prv_mem[k_r] <= '0;
          sweep_r <= '0;
          if (32'(k_r) == NUM_UNKNOWNS - 1) begin
            k_r <= '0;
            c_r <= CW'(NUM_UNKNOWNS);
            state_r <= (limit_r == '0) ? S_EMIT : S_RD;
          end else k_r <= k_r + KW'(1);
        end
        // Address of the current column is on the memory this cycle.
        S_RD: state_r <= S_MUL;
        S_MUL: begin
          // Seed the numerator from the constant, else form the product.
          if (32'(c_r) == NUM_UNKNOWNS) begin
            acc_r <= 64'(rd_r) <<< FRAC_BITS;
            c_r <= '0;
            state_r <= S_RD;
          end else begin
            prod_r <= 64'(rd_r) * 64'(xval);
            pdiag_r <= (KW'(c_r) == k_r);
            if (KW'(c_r) == k_r) diag_r <= rd_r;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          // Subtract the product unless it is the diagonal, then advance.
          if (!pdiag_r) acc_r <= sub_res;
          if (32'(c_r) == NUM_UNKNOWNS - 1) state_r <= S_DIVGO;
          else begin
            c_r <= c_r + CW'(1);
            state_r <= S_RD;
          end
        end
        S_DIVGO: state_r <= S_DIVW;
        S_DIVW: if (dsts.done) begin
          cur_mem[k_r] <= dquo;
          c_r <= CW'(NUM_UNKNOWNS);
          if (32'(k_r) == NUM_UNKNOWNS - 1) begin
            k_r <= '0;
            conv_r <= 1'b1;
            sweep_r <= sweep_r + LIMIT_W'(1);
            state_r <= S_CHK;
          end else begin
            k_r <= k_r + KW'(1);
            state_r <= S_RD;
          end
        end
        S_CHK: begin
          // Compare against last sweep and roll the copy forward.
          if (!(mag < 64'(tol_r))) conv_r <= 1'b0;
          prv_mem[k_r] <= cur_mem[k_r];
          if (32'(k_r) == NUM_UNKNOWNS - 1) begin
            k_r <= '0;
            if ((conv_r && (mag < 64'(tol_r))) || sweep_r == limit_r)
              state_r <= S_EMIT;
            else state_r <= S_RD;
          end else k_r <= k_r + KW'(1);
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (out_ch.valid && out_ch.out_last) begin
              out_ch.valid <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              out_ch.valid <= 1'b1;
              out_ch.var_index <= ROW_W'(k_r);
              out_ch.value <= cur_mem[k_r];
              out_ch.out_last <= (32'(k_r) == NUM_UNKNOWNS - 1);
              k_r <= k_r + KW'(1);
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  property p_no_in_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_LOAD) |-> !in_ch.ready;
  endproperty
  a_no_in_busy: assert property (p_no_in_busy) else $error("input taken mid solve");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !dsts.busy) else $error("divider restarted while busy");
  a_sweep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (sweep_r < limit_r) || (limit_r == '0) || $past(state_r == S_CHK))
    else $error("sweep past limit");
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for gauss_seidel_linear_solver_core: directed table, then random solves
// checked against an in-bench Gauss-Seidel predictor. Depends on gsls_pkg and gsls_if.
`default_nettype none
module tb;
  import gsls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N        = NUM_UNKNOWNS_DEF;
  localparam int NCOL     = N + 1;
  localparam int FRAC     = FRAC_BITS_DEF;
  localparam int WDOG_MAX = 100000;
  localparam int S32_MAX  = 32'h7fffffff;
  localparam int S32_MIN  = 32'h80000000;
  localparam longint S64_MAX = 64'h7fffffffffffffff;
  localparam longint S64_MIN = 64'h8000000000000000;
  localparam int ONE      = 32'h00010000;
  localparam int THREE    = 32'h00030000;

  typedef struct {
    logic [ROW_W-1:0]  var_index;
    logic [DATA_W-1:0] value;
    logic              out_last;
  } unknown_t;

  typedef struct {
    bit          do_cfg;
    int          lim;
    int          tol;
    logic [2:0]  row;
    logic [3:0]  col;
    int          coeff;
    bit          last;
    bit          typed;
    int          exp0;
    int          exp_rest;
  } drow_t;

  logic clk;
  logic rst_n;
  gsls_in_if  in_ch();
  gsls_out_if out_ch();
  gsls_cfg_if cfg_ch();

  gauss_seidel_linear_solver_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  int          coeff_mem [N*NCOL];
  int          sol_cur [N];
  int          sol_prev [N];
  logic [15:0] iter_limit;
  logic [30:0] tol_reg;

  unknown_t pending_vars [$];
  int errors;
  int snd_idle_pct;
  int rcv_idle_pct;
  int wdog;
  int items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sub_sat(longint acc, longint p);
    if (p > 0 && acc < S64_MIN + p) return S64_MIN;
    if (p < 0 && acc > S64_MAX + p) return S64_MAX;
    return acc - p;
  endfunction

  function automatic int div_sat(longint num, int den);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    bit neg;
    if (den == 0) begin
      if (num > 0) return S32_MAX;
      if (num < 0) return S32_MIN;
      return 0;
    end
    mn  = (num < 0) ? 64'(-num) : 64'(num);
    md  = (den < 0) ? 64'(-longint'(den)) : 64'(longint'(den));
    neg = (num < 0) != (den < 0);
    q   = mn / md;
    if (neg) begin
      if (q >= 64'h80000000) return S32_MIN;
      return int'(-longint'(q));
    end
    if (q > 64'h7fffffff) return S32_MAX;
    return int'(q);
  endfunction

  // Run all sweeps of a solve and queue the N expected unknowns.
  task automatic solve_system();
    longint acc;
    longint d;
    bit conv;
    for (int k = 0; k < N; k++) begin
      sol_cur[k]  = 0;
      sol_prev[k] = 0;
    end
    for (int s = 0; s < int'(iter_limit); s++) begin
      conv = 1'b1;
      for (int k = 0; k < N; k++) begin
        acc = longint'(coeff_mem[k*NCOL + N]) * (longint'(1) << FRAC);
        for (int i = 0; i < N; i++)
          if (i != k) acc = sub_sat(acc, longint'(coeff_mem[k*NCOL + i]) * longint'(sol_cur[i]));
        sol_cur[k] = div_sat(acc, coeff_mem[k*NCOL + k]);
      end
      for (int k = 0; k < N; k++) begin
        d = longint'(sol_cur[k]) - longint'(sol_prev[k]);
        if (d < 0) d = -d;
        if (!(d < longint'(tol_reg))) conv = 1'b0;
      end
      if (conv) break;
      sol_prev = sol_cur;
    end
    for (int k = 0; k < N; k++)
      pending_vars.push_back('{3'(k), sol_cur[k], k == N-1});
  endtask

  // Hold the input side low until every unknown is back, then let the core settle.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_vars.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_ITER_LIMIT) iter_limit = val[15:0];
    else tol_reg = val[30:0];
  endtask

  // Send one request; entered and left at a falling edge.
  task automatic send_coeff(logic [2:0] r, logic [3:0] c, int v, bit last,
                            bit typed = 0, int e0 = 0, int er = 0);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.row       = r;
    in_ch.col       = c;
    in_ch.coeff     = v;
    in_ch.load_last = last;
    do @(posedge clk); while (!in_ch.ready);
    items++;
    if (c <= 4'(N)) coeff_mem[int'(r)*NCOL + int'(c)] = v;
    if (last) begin
      if (typed) begin
        for (int k = 0; k < N; k++)
          pending_vars.push_back('{3'(k), (k == 0) ? e0 : er, k == N-1});
      end else begin
        solve_system();
      end
    end
    @(negedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Compare each delivered unknown with the oldest expectation
  always @(posedge clk) begin
    unknown_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_vars.size() == 0) begin
        $display("%0t unexpected result: idx %0d value %h last %b", $realtime,
                 out_ch.var_index, out_ch.value, out_ch.out_last);
        errors++;
      end else begin
        e = pending_vars.pop_front();
        if (out_ch.var_index !== e.var_index) begin
          $display("%0t var_index mismatch: expected %0d actual %0d", $realtime,
                   e.var_index, out_ch.var_index);
          errors++;
        end
        if (out_ch.value !== e.value) begin
          $display("%0t value mismatch (idx %0d): expected %h actual %h", $realtime,
                   e.var_index, e.value, out_ch.value);
          errors++;
        end
        if (out_ch.out_last !== e.out_last) begin
          $display("%0t out_last mismatch (idx %0d): expected %b actual %b", $realtime,
                   e.var_index, e.out_last, out_ch.out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("%0t watchdog expired, %0d results outstanding", $realtime,
                 pending_vars.size());
        $display("[gauss_seidel_linear_solver_core] ERROR");
        $finish;
      end
    end
  end

  function automatic int dom_coeff(int r, int c);
    int mag;
    if (c == N) return int'($urandom);
    if (c == r) mag = $urandom_range(9 * ONE, 40 * ONE);
    else mag = $urandom_range(0, ONE - 1);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // One random solve: settings, a load of well-formed or noisy content, then results.
  task automatic random_solve();
    int kind;
    int lim;
    int tol;
    int pos [$];
    int j;
    int t;
    logic [3:0] nc;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: tol = 0;
      1: tol = $urandom_range(1, 200);
      2: tol = $urandom & S32_MAX;
      default: tol = S32_MAX;
    endcase
    if (kind <= 6) lim = (tol == 0) ? $urandom_range(1, 8) : $urandom_range(1, 24);
    else if (kind <= 8) lim = $urandom_range(1, 4);
    else lim = $urandom_range(1, 3);
    if ($urandom_range(0, 11) == 0) lim = 0;
    cfg_write(REG_ITER_LIMIT, 32'(lim));
    cfg_write(REG_TOLERANCE, 32'(tol));
    // positions: full reload in random order, or a few scattered edits
    if (kind == 7 || kind == 8) begin
      repeat ($urandom_range(1, 6)) pos.push_back($urandom_range(0, N*NCOL - 1));
    end else begin
      for (int p = 0; p < N*NCOL; p++) pos.push_back(p);
      for (int p = N*NCOL - 1; p > 0; p--) begin
        j = $urandom_range(0, p);
        t = pos[p];
        pos[p] = pos[j];
        pos[j] = t;
      end
    end
    for (int p = 0; p < pos.size(); p++) begin
      if ($urandom_range(0, 99) < 8) begin
        nc = 4'($urandom_range(N + 1, 15));
        send_coeff(3'($urandom), nc, int'($urandom), 1'b0);
      end
      send_coeff(3'(pos[p] / NCOL), 4'(pos[p] % NCOL),
                 (kind <= 6) ? dom_coeff(pos[p] / NCOL, pos[p] % NCOL) : int'($urandom),
                 (p == pos.size() - 1) && ($urandom_range(0, 9) != 0));
    end
    // finish with an ignored position carrying the start flag if not yet started
    if (pending_vars.size() == 0) begin
      nc = 4'($urandom_range(N + 1, 15));
      send_coeff(3'($urandom), nc, int'($urandom), 1'b1);
    end
  endtask

  drow_t dtab [] = '{
    '{1, 0, 66, 0, 0, 0, 1, 1, 0, 0},
    '{1, 1, S32_MAX, 7, 8, THREE, 1, 1, THREE, THREE},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 2, 0, 3, 9, S32_MAX, 1, 1, S32_MAX, THREE},
    '{0, 0, 0, 0, 8, S32_MIN, 1, 1, S32_MIN, THREE},
    '{0, 0, 0, 0, 8, 0, 1, 1, 0, THREE},
    '{0, 0, 0, 0, 0, ONE, 0, 0, 0, 0},
    '{1, 65535, S32_MAX, 0, 8, S32_MAX, 1, 1, S32_MAX, THREE},
    '{0, 0, 0, 4, 4, 32'hffff0000, 0, 0, 0, 0},
    '{0, 0, 0, 1, 0, S32_MAX, 0, 0, 0, 0},
    '{0, 0, 0, 2, 1, S32_MIN, 0, 0, 0, 0},
    '{0, 0, 0, 3, 2, 32'hffffffff, 0, 0, 0, 0},
    '{0, 0, 0, 5, 15, 32'h12345678, 0, 0, 0, 0},
    '{1, 3, 66, 6, 6, 32'h00008000, 1, 0, 0, 0},
    '{0, 0, 0, 7, 7, S32_MAX, 0, 0, 0, 0},
    '{0, 0, 0, 7, 8, S32_MIN, 1, 0, 0, 0},
    '{1, 5, ONE, 1, 0, 0, 1, 0, 0, 0}
  };

  initial begin
    errors = 0;
    wdog = 0;
    items = 0;
    snd_idle_pct = 18;
    rcv_idle_pct = 49;
    iter_limit = ITER_LIMIT_RST;
    tol_reg = TOLERANCE_RST;
    for (int i = 0; i < N*NCOL; i++) coeff_mem[i] = 0;
    in_ch.valid = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.coeff = '0;
    in_ch.load_last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; the matrix gets a known fill after the empty solve
    for (int i = 0; i < dtab.size(); i++) begin
      if (dtab[i].do_cfg) begin
        cfg_write(REG_ITER_LIMIT, 32'(dtab[i].lim));
        cfg_write(REG_TOLERANCE, 32'(dtab[i].tol));
      end
      send_coeff(dtab[i].row, dtab[i].col, dtab[i].coeff, dtab[i].last,
                 dtab[i].typed, dtab[i].exp0, dtab[i].exp_rest);
      if (i == 0) begin
        // identity diagonal, constant 3.0 in every row
        for (int r = 0; r < N; r++)
          for (int c = 0; c < NCOL; c++)
            send_coeff(3'(r), 4'(c), (c == r) ? ONE : (c == N) ? THREE : 0, 1'b0);
      end
    end

    // Random solves across the three idle profiles
    while (items < 320) begin
      if (items < 110) begin
        snd_idle_pct = 18;
        rcv_idle_pct = 49;
      end else if (items < 220) begin
        snd_idle_pct = 49;
        rcv_idle_pct = 18;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      random_solve();
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[gauss_seidel_linear_solver_core] OK");
    end else begin
      $display("[gauss_seidel_linear_solver_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hdl/gsls_pkg.sv
hdl/gsls_if.sv
hdl/gsls_div.sv
hdl/gauss_seidel_linear_solver_core.sv
tb/sv/tb.sv
